FILE: src/rrpt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the round-robin poll table.
// No dependencies; the store, controller, top level and checker in src use this package.
package rrpt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int MAX_IDX_W    = 8;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_POLL   = 3'd3,
        OP_PEEK   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_AT_END = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_APPEND,
        S_FETCH_RD,
        S_FETCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [63:0] device_address;
        logic [7:0]  endpoint;
        logic [15:0] cluster;
    } entry_t;

    typedef struct packed {
        logic                 we;
        logic [MAX_IDX_W-1:0] waddr;
        entry_t               wdata;
        logic                 re;
        logic [MAX_IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

FILE: src/rrpt_cmd_if.sv
`timescale 1ns / 1ps
// Command channel: one word carries an operation and a key.
// No dependencies.
interface rrpt_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [63:0] device_address;
    logic [7:0]  endpoint;
    logic [15:0] cluster;

    modport source (output valid, op, device_address, endpoint, cluster, input ready);
    modport sink (input valid, op, device_address, endpoint, cluster, output ready);
endinterface

FILE: src/rrpt_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: one word carries the status and any emitted entry.
// No dependencies.
interface rrpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        entry_valid;
    logic [63:0] entry_address;
    logic [7:0]  entry_endpoint;
    logic [15:0] entry_cluster;
    logic [4:0]  entry_count;

    modport source (output valid, status, entry_valid, entry_address, entry_endpoint,
                    entry_cluster, entry_count, input ready);
    modport sink (input valid, status, entry_valid, entry_address, entry_endpoint,
                  entry_cluster, entry_count, output ready);
endinterface

FILE: src/rrpt_store.sv
`timescale 1ns / 1ps
// Entry memory: one write port and one registered read port.
// Depends on rrpt_pkg.
module rrpt_store #(
    parameter int CAPACITY = rrpt_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  rrpt_pkg::mem_req_t req,
    output rrpt_pkg::entry_t   rdata
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    rrpt_pkg::entry_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[IDX_W-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr[IDX_W-1:0]];
        end
    end

endmodule

FILE: src/rrpt_ctrl.sv
`timescale 1ns / 1ps
// Sequencer with the shared key compare and index incrementer, plus the result register.
// Depends on rrpt_pkg, rrpt_cmd_if and rrpt_rsp_if.
module rrpt_ctrl #(
    parameter int CAPACITY = rrpt_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    rrpt_cmd_if.sink           cmd,
    rrpt_rsp_if.source         rsp,
    output rrpt_pkg::mem_req_t mem_req,
    input  rrpt_pkg::entry_t   mem_rdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    rrpt_pkg::state_t  state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    rrpt_pkg::entry_t  key_reg, key_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cursor_reg, cursor_next;
    rrpt_pkg::status_t status_reg, status_next;
    rrpt_pkg::entry_t  hit_reg, hit_next;
    logic              hit_valid_reg, hit_valid_next;

    logic              out_valid_reg;
    rrpt_pkg::status_t out_status_reg;
    logic              out_hit_valid_reg;
    rrpt_pkg::entry_t  out_hit_reg;
    logic [4:0]        out_count_reg;

    logic             cmd_fire;
    logic             out_free;
    logic             key_match;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_dec;
    logic             scan_last;
    logic             table_full;

    assign cmd_fire   = cmd.valid && cmd.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign key_match  = (mem_rdata == key_reg);
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign idx_dec    = idx_reg - CNT_W'(1);
    assign scan_last  = !(idx_inc < count_reg);
    assign table_full = (count_reg >= CNT_W'(CAPACITY));

    assign cmd.ready       = (state_reg == rrpt_pkg::S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_valid = out_hit_valid_reg;
    assign rsp.entry_address  = out_hit_reg.device_address;
    assign rsp.entry_endpoint = out_hit_reg.endpoint;
    assign rsp.entry_cluster  = out_hit_reg.cluster;
    assign rsp.entry_count    = out_count_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrpt_pkg::S_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = rrpt_pkg::S_DONE;
                    unique case (cmd.op)
                        rrpt_pkg::OP_ADD:
                        begin
                            if (!table_full)
                            begin
                                state_next = (count_reg == '0) ? rrpt_pkg::S_APPEND
                                                               : rrpt_pkg::S_RD;
                            end
                        end
                        rrpt_pkg::OP_REMOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = rrpt_pkg::S_RD;
                            end
                        end
                        rrpt_pkg::OP_POLL:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = rrpt_pkg::S_FETCH_RD;
                            end
                        end
                        rrpt_pkg::OP_PEEK:
                        begin
                            if (count_reg != '0 && cursor_reg < count_reg)
                            begin
                                state_next = rrpt_pkg::S_FETCH_RD;
                            end
                        end
                        default:
                        begin
                            state_next = rrpt_pkg::S_DONE;
                        end
                    endcase
                end
            end
            rrpt_pkg::S_RD:
            begin
                state_next = rrpt_pkg::S_CMP;
            end
            rrpt_pkg::S_CMP:
            begin
                if (key_match)
                begin
                    if (op_reg == rrpt_pkg::OP_REMOVE && !scan_last)
                    begin
                        state_next = rrpt_pkg::S_SH_RD;
                    end
                    else
                    begin
                        state_next = rrpt_pkg::S_DONE;
                    end
                end
                else if (!scan_last)
                begin
                    state_next = rrpt_pkg::S_RD;
                end
                else if (op_reg == rrpt_pkg::OP_ADD)
                begin
                    state_next = rrpt_pkg::S_APPEND;
                end
                else
                begin
                    state_next = rrpt_pkg::S_DONE;
                end
            end
            rrpt_pkg::S_SH_RD:
            begin
                state_next = rrpt_pkg::S_SH_WR;
            end
            rrpt_pkg::S_SH_WR:
            begin
                state_next = scan_last ? rrpt_pkg::S_DONE : rrpt_pkg::S_SH_RD;
            end
            rrpt_pkg::S_APPEND:
            begin
                state_next = rrpt_pkg::S_DONE;
            end
            rrpt_pkg::S_FETCH_RD:
            begin
                state_next = rrpt_pkg::S_FETCH;
            end
            rrpt_pkg::S_FETCH:
            begin
                state_next = rrpt_pkg::S_DONE;
            end
            rrpt_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = rrpt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rrpt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        status_next    = status_reg;
        hit_next       = hit_reg;
        hit_valid_next = hit_valid_reg;
        mem_req        = '0;
        unique case (state_reg)
            rrpt_pkg::S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next        = cmd.op;
                    key_next       = '{device_address: cmd.device_address,
                                       endpoint: cmd.endpoint, cluster: cmd.cluster};
                    status_next    = rrpt_pkg::ST_OK;
                    hit_next       = '0;
                    hit_valid_next = 1'b0;
                    idx_next       = '0;
                    unique case (cmd.op)
                        rrpt_pkg::OP_ADD:
                        begin
                            if (table_full)
                            begin
                                status_next = rrpt_pkg::ST_FULL;
                            end
                        end
                        rrpt_pkg::OP_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        rrpt_pkg::OP_POLL:
                        begin
                            if (count_reg != '0)
                            begin
                                if (cursor_reg >= count_reg)
                                begin
                                    cursor_next = '0;
                                end
                                else
                                begin
                                    idx_next = cursor_reg;
                                end
                            end
                        end
                        rrpt_pkg::OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = rrpt_pkg::ST_EMPTY;
                            end
                            else if (cursor_reg >= count_reg)
                            begin
                                status_next = rrpt_pkg::ST_AT_END;
                            end
                            else
                            begin
                                idx_next = cursor_reg;
                            end
                        end
                        default:
                        begin
                            idx_next = '0;
                        end
                    endcase
                end
            end
            rrpt_pkg::S_RD, rrpt_pkg::S_SH_RD, rrpt_pkg::S_FETCH_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = rrpt_pkg::MAX_IDX_W'(idx_reg[IDX_W-1:0]);
            end
            rrpt_pkg::S_CMP:
            begin
                if (key_match)
                begin
                    if (op_reg == rrpt_pkg::OP_REMOVE)
                    begin
                        idx_next = idx_inc;
                        if (scan_last)
                        begin
                            count_next  = count_reg - CNT_W'(1);
                            cursor_next = '0;
                        end
                    end
                end
                else if (!scan_last)
                begin
                    idx_next = idx_inc;
                end
            end
            rrpt_pkg::S_SH_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = rrpt_pkg::MAX_IDX_W'(idx_dec[IDX_W-1:0]);
                mem_req.wdata = mem_rdata;
                idx_next      = idx_inc;
                if (scan_last)
                begin
                    count_next  = count_reg - CNT_W'(1);
                    cursor_next = '0;
                end
            end
            rrpt_pkg::S_APPEND:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = rrpt_pkg::MAX_IDX_W'(count_reg[IDX_W-1:0]);
                mem_req.wdata = key_reg;
                count_next    = count_reg + CNT_W'(1);
                cursor_next   = '0;
            end
            rrpt_pkg::S_FETCH:
            begin
                hit_next       = mem_rdata;
                hit_valid_next = 1'b1;
                if (op_reg == rrpt_pkg::OP_POLL)
                begin
                    cursor_next = idx_inc;
                end
            end
            rrpt_pkg::S_DONE:
            begin
                mem_req = '0;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrpt_pkg::S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            if (state_reg == rrpt_pkg::S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        status_reg    <= status_next;
        hit_reg       <= hit_next;
        hit_valid_reg <= hit_valid_next;
        if (state_reg == rrpt_pkg::S_DONE && out_free)
        begin
            out_status_reg    <= status_reg;
            out_hit_valid_reg <= hit_valid_reg;
            out_hit_reg       <= hit_reg;
            out_count_reg     <= 5'(count_reg);
        end
    end

endmodule

FILE: src/round_robin_poll_table.sv
`timescale 1ns / 1ps
// Round-robin poll table: ordered key store with add, remove, clear, poll and peek.
// Add and remove scan the table entry by entry through the single memory read port
// and key comparator; remove then shifts each later entry down by one slot.
// Reset empties the table and zeroes the cursor; memory contents are not cleared.
module round_robin_poll_table #(
    parameter int CAPACITY = rrpt_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rrpt_cmd_if.sink   cmd,
    rrpt_rsp_if.source rsp
);

    rrpt_pkg::mem_req_t mem_req;
    rrpt_pkg::entry_t   mem_rdata;

    rrpt_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    rrpt_store #(
        .CAPACITY(CAPACITY)
    ) u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

FILE: src/rrpt_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the round-robin poll table, bound to the top level.
// Depends on rrpt_pkg and round_robin_poll_table.
module rrpt_checker #(
    parameter int CAPACITY = rrpt_pkg::CAPACITY_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic        rsp_entry_valid,
    input logic [63:0] rsp_entry_address,
    input logic [7:0]  rsp_entry_endpoint,
    input logic [15:0] rsp_entry_cluster,
    input logic [4:0]  rsp_entry_count
);

    // An accepted command always keeps the block busy for the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command port ready right after an accepted word");

    a_zero_when_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_entry_valid |-> rsp_entry_address == 64'd0
            && rsp_entry_endpoint == 8'd0 && rsp_entry_cluster == 16'd0)
        else $error("entry fields nonzero without an emitted entry");

    a_entry_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_entry_valid |-> rsp_status == rrpt_pkg::ST_OK)
        else $error("emitted entry with a non-ok status");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == rrpt_pkg::ST_FULL |-> 32'(rsp_entry_count) ==
            (CAPACITY % 32))
        else $error("refused add while the table is not full");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_entry_address) && $stable(rsp_entry_count))
        else $error("stalled response word changed");

endmodule

bind round_robin_poll_table rrpt_checker #(
    .CAPACITY(CAPACITY)
) u_rrpt_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_entry_valid    (rsp.entry_valid),
    .rsp_entry_address  (rsp.entry_address),
    .rsp_entry_endpoint (rsp.entry_endpoint),
    .rsp_entry_cluster  (rsp.entry_cluster),
    .rsp_entry_count    (rsp.entry_count)
);

FILE: tb/poll_table_reply_check.sv
`timescale 1ns / 1ps
// Reply checker for the round-robin poll table: mirrors the table, cursor and count.
// It watches both channels, predicts each reply and compares it field by field.
// Depends on rrpt_pkg and the rrpt_cmd_if and rrpt_rsp_if interfaces.
module poll_table_reply_check #(
    parameter int CAPACITY = rrpt_pkg::CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    rrpt_cmd_if  cmd,
    rrpt_rsp_if  rsp,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        rrpt_pkg::status_t status;
        logic              entry_valid;
        rrpt_pkg::entry_t  entry;
        logic [4:0]        count;
    } poll_reply_t;

    rrpt_pkg::entry_t slots [CAPACITY];
    int               table_fill;
    int               cursor_pos;
    poll_reply_t      replies_due [$];
    poll_reply_t      want;
    poll_reply_t      next_reply;

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v)
        begin
            log_failure($sformatf("reply %s mismatch: expected %h, got %h",
                                  name, exp_v, got_v));
        end
    endtask

    function automatic int find_slot(input rrpt_pkg::entry_t key);
        int i;
        for (i = 0; i < table_fill; i++)
        begin
            if (slots[i] == key)
            begin
                return i;
            end
        end
        return table_fill;
    endfunction

    task automatic apply_word(input logic [2:0] op, input rrpt_pkg::entry_t key,
                              output poll_reply_t r);
        int pos;
        int i;
        r = '0;
        r.status = rrpt_pkg::ST_OK;
        case (op)
            rrpt_pkg::OP_ADD:
            begin
                if (table_fill >= CAPACITY)
                begin
                    r.status = rrpt_pkg::ST_FULL;
                end
                else if (find_slot(key) == table_fill)
                begin
                    slots[table_fill] = key;
                    table_fill++;
                    cursor_pos = 0;
                end
            end
            rrpt_pkg::OP_REMOVE:
            begin
                pos = find_slot(key);
                if (pos < table_fill)
                begin
                    for (i = pos; i + 1 < table_fill; i++)
                    begin
                        slots[i] = slots[i + 1];
                    end
                    table_fill--;
                    cursor_pos = 0;
                end
            end
            rrpt_pkg::OP_CLEAR:
            begin
                table_fill = 0;
                cursor_pos = 0;
            end
            rrpt_pkg::OP_POLL:
            begin
                if (cursor_pos >= table_fill && table_fill != 0)
                begin
                    cursor_pos = 0;
                end
                if (cursor_pos < table_fill)
                begin
                    r.entry_valid = 1'b1;
                    r.entry = slots[cursor_pos];
                    cursor_pos++;
                end
            end
            rrpt_pkg::OP_PEEK:
            begin
                if (table_fill == 0)
                begin
                    r.status = rrpt_pkg::ST_EMPTY;
                end
                else if (cursor_pos >= table_fill)
                begin
                    r.status = rrpt_pkg::ST_AT_END;
                end
                else
                begin
                    r.entry_valid = 1'b1;
                    r.entry = slots[cursor_pos];
                end
            end
            default:
            begin
            end
        endcase
        r.count = 5'(table_fill);
    endtask

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replies_due.delete();
            table_fill = 0;
            cursor_pos = 0;
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    log_failure("reply word arrived with none expected");
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_field("status", 64'(want.status), 64'(rsp.status));
                    check_field("entry_valid", 64'(want.entry_valid),
                                64'(rsp.entry_valid));
                    check_field("entry_address", want.entry.device_address,
                                rsp.entry_address);
                    check_field("entry_endpoint", 64'(want.entry.endpoint),
                                64'(rsp.entry_endpoint));
                    check_field("entry_cluster", 64'(want.entry.cluster),
                                64'(rsp.entry_cluster));
                    check_field("entry_count", 64'(want.count), 64'(rsp.entry_count));
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                apply_word(cmd.op, {cmd.device_address, cmd.endpoint, cmd.cluster},
                           next_reply);
                replies_due = {replies_due, next_reply};
            end
            pending <= replies_due.size();
        end
    end

endmodule

FILE: tb/round_robin_poll_table_tb.sv
`timescale 1ns / 1ps
// Top of the poll table testbench: clock, reset, command stimulus and reply back-pressure.
// Depends on rrpt_pkg, both channel interfaces, the block and poll_table_reply_check.
module round_robin_poll_table_tb;

    localparam int          CAP             = rrpt_pkg::CAPACITY_DEF;
    localparam logic [2:0]  OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  OP_UNUSED_LAST  = 3'd7;
    localparam int          POOL_SIZE       = 20;
    localparam int          PHASE_WORDS     = 150;
    localparam int          PHASES          = 12;
    localparam int          HOLD_CYCLES     = 300;

    logic             clk;
    logic             rst_n;
    int               fail_count;
    int               pending;
    bit               calm;
    int               holds_asked;
    int               holds_done;
    int               hold_left;
    rrpt_pkg::entry_t key_pool [POOL_SIZE];

    rrpt_cmd_if cmd ();
    rrpt_rsp_if rsp ();

    round_robin_poll_table #(.CAPACITY(CAP)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    poll_table_reply_check #(.CAPACITY(CAP)) u_reply_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("round_robin_poll_table_tb: FAIL");
        $finish;
    end

    initial
    begin
        holds_done = 0;
        hold_left = 0;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= calm || ($urandom_range(99) >= 9);
            end
        end
    end

    function automatic rrpt_pkg::entry_t random_key();
        rrpt_pkg::entry_t k;
        k.device_address = {$urandom, $urandom};
        k.endpoint = 8'($urandom);
        k.cluster = 16'($urandom);
        return k;
    endfunction

    function automatic rrpt_pkg::entry_t pick_key();
        if ($urandom_range(99) < 10)
        begin
            return random_key();
        end
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // Keys share addresses, endpoints and clusters so that partial matches are common.
    task automatic refresh_pool();
        rrpt_pkg::entry_t parts [4];
        int               i;
        for (i = 0; i < 4; i++)
        begin
            parts[i] = random_key();
        end
        for (i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i].device_address = parts[$urandom_range(3)].device_address;
            key_pool[i].endpoint = parts[$urandom_range(2)].endpoint;
            key_pool[i].cluster = parts[$urandom_range(2)].cluster;
        end
    endtask

    function automatic logic [2:0] choose_op(input bit filling);
        int r;
        r = $urandom_range(99);
        if (r < (filling ? 55 : 25))
            return rrpt_pkg::OP_ADD;
        if (r < (filling ? 65 : 55))
            return rrpt_pkg::OP_REMOVE;
        if (r < (filling ? 66 : 58))
            return rrpt_pkg::OP_CLEAR;
        if (r < (filling ? 84 : 78))
            return rrpt_pkg::OP_POLL;
        if (r < 95)
            return rrpt_pkg::OP_PEEK;
        return 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    endfunction

    task automatic send_word(input logic [2:0] op, input rrpt_pkg::entry_t key);
        cmd.valid <= 1'b1;
        cmd.op <= op;
        cmd.device_address <= key.device_address;
        cmd.endpoint <= key.endpoint;
        cmd.cluster <= key.cluster;
        @(posedge clk);
        while (!cmd.ready)
        begin
            @(posedge clk);
        end
        if (!calm && $urandom_range(99) < 9)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic drain_replies();
        cmd.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    initial
    begin
        rrpt_pkg::entry_t ones_key;
        rrpt_pkg::entry_t zero_key;
        rrpt_pkg::entry_t near_key;
        logic [2:0]       op;
        int               phase;
        int               done;
        int               u;

        ones_key = '1;
        zero_key = '0;
        near_key = ones_key;
        near_key.endpoint = 8'h00;
        calm = 1'b0;
        holds_asked = 0;
        cmd.valid <= 1'b0;
        cmd.op <= rrpt_pkg::OP_CLEAR;
        cmd.device_address <= '0;
        cmd.endpoint <= '0;
        cmd.cluster <= '0;
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(rrpt_pkg::OP_PEEK, random_key());
        send_word(rrpt_pkg::OP_POLL, random_key());
        send_word(rrpt_pkg::OP_ADD, ones_key);
        send_word(rrpt_pkg::OP_ADD, zero_key);
        send_word(rrpt_pkg::OP_ADD, ones_key);
        send_word(rrpt_pkg::OP_PEEK, random_key());
        send_word(rrpt_pkg::OP_POLL, random_key());
        send_word(rrpt_pkg::OP_POLL, random_key());
        send_word(rrpt_pkg::OP_PEEK, random_key());
        send_word(rrpt_pkg::OP_POLL, random_key());
        send_word(rrpt_pkg::OP_REMOVE, near_key);
        send_word(rrpt_pkg::OP_REMOVE, ones_key);
        send_word(rrpt_pkg::OP_PEEK, random_key());
        for (u = OP_UNUSED_FIRST; u <= OP_UNUSED_LAST; u++)
        begin
            send_word(3'(u), random_key());
        end
        send_word(rrpt_pkg::OP_CLEAR, random_key());
        send_word(rrpt_pkg::OP_PEEK, random_key());
        send_word(rrpt_pkg::OP_POLL, random_key());

        for (phase = 0; phase < PHASES; phase++)
        begin
            refresh_pool();
            calm = (phase == 3);
            if (phase == 5)
            begin
                holds_asked++;
            end
            if (phase == 7)
            begin
                drain_replies();
            end
            done = 0;
            while (done < PHASE_WORDS)
            begin
                op = choose_op(phase % 2 == 0);
                send_word(op, pick_key());
                if (op <= rrpt_pkg::OP_PEEK)
                begin
                    done++;
                end
            end
        end

        drain_replies();
        repeat (60) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("round_robin_poll_table_tb: PASS");
        end
        else
        begin
            $display("round_robin_poll_table_tb: FAIL");
        end
        $finish;
    end

endmodule
